>>> src/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// No dependencies; used by every other file under src.
`default_nettype none

package pse_pkg;

   localparam int VAL_W  = 48;
   localparam int MODE_W = 3;
   localparam int STAT_W = 3;
   localparam int ALU_W  = VAL_W + 2;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_UNDER = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_DIVZ  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_SAT   = 3'd4;

   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> src/postfix_stack_evaluator.sv
// Top level: postfix evaluator sequencer, operand stack RAM and shared ALU.
// Depends on pse_pkg, pse_ram and pse_alu.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser=mode, tdata=operand, tlast=last_token
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata=value, tuser=status
//
// Each accepted item keeps the sequencer busy until its states finish: a push, an add/sub
// (or a negate, which is a sub with one operand), a multiply or a divide, then a stack-top
// read on a last item and any wait for a free result register; the shared ALU steps one
// product or quotient bit per cycle and the stack RAM gives one registered read per cycle.
// Reset clears the sequencer, stack count, error code and rsp_tvalid.
// req_tready is high only while the sequencer is idle; a held result does not block
// the next item unless that item is also last.
`default_nettype none

module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic signed [pse_pkg::VAL_W-1:0]   req_tdata,  // [47:0] operand
   input  wire logic        [pse_pkg::MODE_W-1:0]  req_tuser,  // [2:0] mode
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic signed      [pse_pkg::VAL_W-1:0]   rsp_tdata,  // [47:0] value
   output logic             [pse_pkg::STAT_W-1:0]  rsp_tuser   // [2:0] status
);

   localparam int VW       = pse_pkg::VAL_W;
   localparam int AW       = pse_pkg::ALU_W;
   localparam int SW       = pse_pkg::STAT_W;
   localparam int IDX_W    = $clog2(STACK_DEPTH);
   localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int STEP_W   = $clog2(VW + FRAC_BITS);
   localparam int MUL_LAST = VW - 1;
   localparam int DIV_LAST = VW + FRAC_BITS - 1;
   localparam int PROD_W   = 2 * VW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_RD_R, ST_RD_L, ST_ADDSUB, ST_MAGL, ST_MAGR,
      ST_MUL, ST_DIV, ST_SIGN, ST_END, ST_TOPRD, ST_EMIT
   } state_type;

   state_type                     state_ff;
   logic [pse_pkg::MODE_W-1:0]    mode_ff;
   logic [VW-1:0]                 opnd_ff;
   logic                          last_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [SW-1:0]                 err_ff;
   logic [VW-1:0]                 lv_ff;
   logic [VW-1:0]                 rv_ff;
   logic [VW-1:0]                 opa_ff;
   logic [VW-1:0]                 opb_ff;
   logic [VW-1:0]                 acc_ff;
   logic [VW:0]                   q_ff;
   logic                          over_ff;
   logic                          neg_ff;
   logic [STEP_W-1:0]             step_ff;
   logic [VW-1:0]                 top_ff;
   logic                          rsp_tvalid_ff;
   logic [VW-1:0]                 rsp_tdata_ff;
   logic [SW-1:0]                 rsp_tuser_ff;

   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W-1:0]  cnt_m2;
   logic              two_up;
   logic              full;
   logic              emit_go;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [VW-1:0]     ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [VW-1:0]     ram_rdata;
   logic [AW-1:0]     alu_x;
   logic [AW-1:0]     alu_y;
   logic              alu_sub;
   logic [AW-1:0]     alu_sum;
   logic              borrow;
   logic              as_ovf;
   logic [VW-1:0]     as_res;
   logic [PROD_W-1:0] prod;
   logic [VW-1:0]     mul_mag;
   logic              mul_over;
   logic [VW-1:0]     fix_mag;
   logic              fix_over;
   logic              fix_sat;
   logic [VW-1:0]     fix_res;

   function automatic logic [SW-1:0] keep_first(input logic [SW-1:0] cur,
                                                 input logic [SW-1:0] code);
      return (cur == pse_pkg::STAT_OK) ? code : cur;
   endfunction

   function automatic logic [AW-1:0] sext(input logic [VW-1:0] v);
      return {{(AW-VW){v[VW-1]}}, v};
   endfunction

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);
   assign two_up = count_ff > CNT_W'(1);
   assign full   = count_ff >= CNT_W'(STACK_DEPTH);

   assign emit_go = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   pse_ram #(
      .WIDTH (VW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pse_alu u_alu (
      .x   (alu_x),
      .y   (alu_y),
      .sub (alu_sub),
      .sum (alu_sum)
   );

   assign borrow = alu_sum[AW-1];

   assign as_ovf = (alu_sum[AW-1] != alu_sum[VW-1]) | (alu_sum[AW-2] != alu_sum[VW-1]);
   assign as_res = as_ovf ? (alu_sum[AW-1] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX)
                          : alu_sum[VW-1:0];

   assign prod     = {acc_ff, opb_ff};
   assign mul_mag  = prod[FRAC_BITS +: VW];
   assign mul_over = |(prod >> (FRAC_BITS + VW));
   assign fix_mag  = (mode_ff == pse_pkg::MODE_MUL) ? mul_mag : q_ff[VW-1:0];
   assign fix_over = (mode_ff == pse_pkg::MODE_MUL) ? mul_over : (over_ff | q_ff[VW]);
   assign fix_sat  = fix_over | (fix_mag[VW-1] & (~neg_ff | (|fix_mag[VW-2:0])));
   assign fix_res  = fix_sat ? (neg_ff ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX)
                             : (neg_ff ? alu_sum[VW-1:0] : fix_mag);

   always_comb begin
      alu_x   = '0;
      alu_y   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_ADDSUB: begin
            alu_x   = sext(lv_ff);
            alu_y   = sext(rv_ff);
            alu_sub = (mode_ff == pse_pkg::MODE_SUB);
         end
         ST_MAGL: begin
            alu_y   = sext(lv_ff);
            alu_sub = 1'b1;
         end
         ST_MAGR: begin
            alu_y   = sext(rv_ff);
            alu_sub = 1'b1;
         end
         ST_MUL: begin
            alu_x = {2'b00, acc_ff};
            alu_y = opb_ff[0] ? {2'b00, opa_ff} : '0;
         end
         ST_DIV: begin
            alu_x   = {1'b0, acc_ff, opa_ff[VW-1]};
            alu_y   = {2'b00, opb_ff};
            alu_sub = 1'b1;
         end
         ST_SIGN: begin
            alu_y   = {2'b00, fix_mag};
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_m2[IDX_W-1:0];
      ram_wdata = fix_res;
      ram_raddr = cnt_m1[IDX_W-1:0];
      case (state_ff)
         ST_DISPATCH: begin
            ram_we    = (mode_ff == pse_pkg::MODE_PUSH) && !full;
            ram_waddr = count_ff[IDX_W-1:0];
            ram_wdata = opnd_ff;
         end
         ST_RD_R: begin
            ram_raddr = cnt_m2[IDX_W-1:0];
         end
         ST_RD_L: begin
            ram_we    = (mode_ff == pse_pkg::MODE_DIV) && (rv_ff == '0);
            ram_wdata = '0;
         end
         ST_ADDSUB: begin
            ram_we    = 1'b1;
            ram_waddr = two_up ? cnt_m2[IDX_W-1:0] : '0;
            ram_wdata = as_res;
         end
         ST_SIGN: begin
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         err_ff        <= pse_pkg::STAT_OK;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !emit_go) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  mode_ff  <= req_tuser;
                  opnd_ff  <= req_tdata;
                  last_ff  <= req_tlast;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               if (mode_ff == pse_pkg::MODE_PUSH) begin
                  if (full) begin
                     err_ff <= keep_first(err_ff, pse_pkg::STAT_FULL);
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= ST_END;
               end else if (mode_ff inside {[pse_pkg::MODE_ADD:pse_pkg::MODE_DIV]}) begin
                  if (count_ff == '0) begin
                     err_ff   <= keep_first(err_ff, pse_pkg::STAT_UNDER);
                     state_ff <= ST_END;
                  end else begin
                     state_ff <= ST_RD_R;
                  end
               end else begin
                  state_ff <= ST_END;
               end
            end
            ST_RD_R: begin
               rv_ff <= ram_rdata;
               if (!two_up) begin
                  if (mode_ff == pse_pkg::MODE_SUB) begin
                     lv_ff    <= '0;
                     state_ff <= ST_ADDSUB;
                  end else begin
                     count_ff <= '0;
                     err_ff   <= keep_first(err_ff, pse_pkg::STAT_UNDER);
                     state_ff <= ST_END;
                  end
               end else begin
                  state_ff <= ST_RD_L;
               end
            end
            ST_RD_L: begin
               lv_ff <= ram_rdata;
               if (mode_ff == pse_pkg::MODE_ADD || mode_ff == pse_pkg::MODE_SUB) begin
                  state_ff <= ST_ADDSUB;
               end else if (mode_ff == pse_pkg::MODE_DIV && rv_ff == '0) begin
                  count_ff <= cnt_m1;
                  err_ff   <= keep_first(err_ff, pse_pkg::STAT_DIVZ);
                  state_ff <= ST_END;
               end else begin
                  state_ff <= ST_MAGL;
               end
            end
            ST_ADDSUB: begin
               if (two_up) begin
                  count_ff <= cnt_m1;
               end
               if (as_ovf) begin
                  err_ff <= keep_first(err_ff, pse_pkg::STAT_SAT);
               end
               state_ff <= ST_END;
            end
            ST_MAGL: begin
               opa_ff   <= lv_ff[VW-1] ? alu_sum[VW-1:0] : lv_ff;
               state_ff <= ST_MAGR;
            end
            ST_MAGR: begin
               opb_ff   <= rv_ff[VW-1] ? alu_sum[VW-1:0] : rv_ff;
               acc_ff   <= '0;
               q_ff     <= '0;
               over_ff  <= 1'b0;
               step_ff  <= '0;
               neg_ff   <= lv_ff[VW-1] ^ rv_ff[VW-1];
               state_ff <= (mode_ff == pse_pkg::MODE_MUL) ? ST_MUL : ST_DIV;
            end
            ST_MUL: begin
               acc_ff  <= alu_sum[VW:1];
               opb_ff  <= {alu_sum[0], opb_ff[VW-1:1]};
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(MUL_LAST)) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_DIV: begin
               acc_ff  <= borrow ? alu_x[VW-1:0] : alu_sum[VW-1:0];
               opa_ff  <= {opa_ff[VW-2:0], 1'b0};
               q_ff    <= {q_ff[VW-1:0], ~borrow};
               over_ff <= over_ff | q_ff[VW];
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DIV_LAST)) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               count_ff <= cnt_m1;
               if (fix_sat) begin
                  err_ff <= keep_first(err_ff, pse_pkg::STAT_SAT);
               end
               state_ff <= ST_END;
            end
            ST_END: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (count_ff == '0) begin
                  top_ff   <= '0;
                  err_ff   <= keep_first(err_ff, pse_pkg::STAT_UNDER);
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_TOPRD;
               end
            end
            ST_TOPRD: begin
               top_ff   <= ram_rdata;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= top_ff;
                  rsp_tuser_ff  <= err_ff;
                  count_ff      <= '0;
                  err_ff        <= pse_pkg::STAT_OK;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item taken while previous item still in work");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_tvalid_ff || rsp_tready))
      |=> (rsp_tvalid && count_ff == '0 && err_ff == pse_pkg::STAT_OK && req_tready))
      else $error("result load did not clear expression state");

endmodule

`default_nettype wire

>>> src/pse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on pse_pkg for default sizes.
`default_nettype none

module pse_ram #(
   parameter int WIDTH = pse_pkg::VAL_W,
   parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/pse_alu.sv
// Shared add/subtract unit used for every arithmetic step of the evaluator.
// Depends on pse_pkg for the datapath width.
`default_nettype none

module pse_alu (
   input  wire logic [pse_pkg::ALU_W-1:0] x,
   input  wire logic [pse_pkg::ALU_W-1:0] y,
   input  wire logic                      sub,
   output logic      [pse_pkg::ALU_W-1:0] sum
);

   logic [pse_pkg::ALU_W-1:0] y_eff;

   assign y_eff = sub ? ~y : y;
   assign sum   = x + y_eff + {{(pse_pkg::ALU_W-1){1'b0}}, sub};

endmodule

`default_nettype wire
